// ===== design/ffba_pkg.sv =====
// Package for the first-fit block allocator: shared types, codes and defaults.
// Used by every module of the block and by its port checker.
package ffba_pkg;

  localparam int unsigned DEF_ARENA_BYTES  = 65536;
  localparam int unsigned DEF_HEADER_BYTES = 16;
  localparam int unsigned DEF_MAX_SEGMENTS = 64;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_EXACT = 2'd1,
    OP_SPLIT = 2'd2,
    OP_FREE  = 2'd3
  } ffba_op_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NOSPACE = 2'd1,
    STATUS_BADADDR = 2'd2,
    STATUS_FULL    = 2'd3
  } ffba_status_e;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [15:0] request_bytes;
    logic [15:0] free_address;
  } ffba_req_t;

  typedef struct packed {
    logic [15:0] payload_address;
    logic [1:0]  status;
  } ffba_rsp_t;

  // One table entry as held by a cell.
  typedef struct packed {
    logic        valid;
    logic        free;
    logic [15:0] off;
    logic [15:0] size;
  } ffba_seg_t;

  // Compare results that a cell registers for the pick stage.
  typedef struct packed {
    logic cand;
    logic exact;
    logic nxt;
    logic prv;
  } ffba_flag_t;

  // Decision of the pick stage.
  typedef struct packed {
    ffba_op_e     op;
    ffba_status_e status;
    logic         merge_next;
    logic         merge_prev;
  } ffba_dec_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic        eval_en;
    logic        apply_en;
    ffba_op_e    op;
    logic        mode;
    logic [15:0] req;
    logic [15:0] addr;
    logic        merge_next;
    logic        merge_prev;
  } ffba_ctrl_t;

endpackage

// ===== design/ffba_cell.sv =====
// One segment cell of the allocator chain: holds one table entry, compares it
// against the current request and shifts to or from its neighbors. Uses ffba_pkg.
module ffba_cell #(
  parameter int unsigned HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES,
  parameter bit          IS_HEAD      = 1'b0,
  parameter logic [15:0] SIZE_RST     = 16'd0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ffba_pkg::ffba_ctrl_t ctrl_i,
  input  ffba_pkg::ffba_seg_t  left_i,
  input  ffba_pkg::ffba_seg_t  right1_i,
  input  ffba_pkg::ffba_seg_t  right2_i,
  input  logic               sel_left_i,
  input  logic               after_left_i,
  input  logic               sel_self_i,
  input  logic               after_self_i,
  input  logic               sel_right_i,
  output ffba_pkg::ffba_seg_t  seg_o,
  output ffba_pkg::ffba_flag_t flag_o,
  output logic [15:0]        addr_o
);
  import ffba_pkg::*;

  localparam logic [15:0] HDR16 = 16'(HEADER_BYTES);
  localparam logic [16:0] HDR17 = 17'(HEADER_BYTES);
  localparam ffba_seg_t SEG_RST = IS_HEAD ?
      ffba_seg_t'{valid: 1'b1, free: 1'b1, off: 16'd0, size: SIZE_RST} : ffba_seg_t'('0);

  ffba_seg_t  seg_q, seg_d;
  ffba_flag_t flag_q, flag_d;
  logic       hit_free;
  logic       size_eq;
  logic       fit;

  always_comb begin
    hit_free = seg_q.valid & ~seg_q.free &
               (({1'b0, seg_q.off} + HDR17) == {1'b0, ctrl_i.addr});
    size_eq  = (seg_q.size == ctrl_i.req);
    fit      = seg_q.valid & seg_q.free &
               (size_eq | ({1'b0, seg_q.size} > ({1'b0, ctrl_i.req} + HDR17)));
    flag_d.cand  = ctrl_i.mode ? hit_free : fit;
    flag_d.exact = size_eq;
    flag_d.nxt   = ctrl_i.mode & hit_free & right1_i.valid & right1_i.free;
    flag_d.prv   = ctrl_i.mode & hit_free & left_i.valid & left_i.free;
  end

  always_comb begin
    seg_d = seg_q;
    if (ctrl_i.apply_en) begin
      case (ctrl_i.op)
        OP_EXACT: begin
          if (sel_self_i) seg_d.free = 1'b0;
        end
        OP_SPLIT: begin
          if (sel_self_i) begin
            seg_d.size = ctrl_i.req;
            seg_d.free = 1'b0;
          end else if (sel_left_i) begin
            // The remainder of the left neighbor becomes a new free segment here.
            seg_d.valid = 1'b1;
            seg_d.free  = 1'b1;
            seg_d.off   = left_i.off + HDR16 + ctrl_i.req;
            seg_d.size  = left_i.size - ctrl_i.req - HDR16;
          end else if (after_left_i) begin
            seg_d = left_i;
          end
        end
        OP_FREE: begin
          if (sel_self_i) begin
            if (ctrl_i.merge_prev) begin
              seg_d = ctrl_i.merge_next ? right2_i : right1_i;
            end else begin
              seg_d.free = 1'b1;
              if (ctrl_i.merge_next) seg_d.size = seg_q.size + right1_i.size + HDR16;
            end
          end else if (sel_right_i && ctrl_i.merge_prev) begin
            // Predecessor absorbs the freed segment and possibly its successor too.
            seg_d.size = seg_q.size + right1_i.size + HDR16 +
                         (ctrl_i.merge_next ? (right2_i.size + HDR16) : 16'd0);
          end else if (after_self_i) begin
            if (ctrl_i.merge_prev && ctrl_i.merge_next) begin
              seg_d = right2_i;
            end else if (ctrl_i.merge_prev || ctrl_i.merge_next) begin
              seg_d = right1_i;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q  <= SEG_RST;
      flag_q <= '0;
    end else begin
      seg_q <= seg_d;
      if (ctrl_i.eval_en) flag_q <= flag_d;
    end
  end

  assign seg_o  = seg_q;
  assign flag_o = flag_q;
  assign addr_o = sel_self_i ? (seg_q.off + HDR16) : 16'd0;

endmodule

// ===== design/ffba_pick.sv =====
// Pick stage of the allocator: finds the first candidate cell, builds the
// position masks for the chain and decides the operation. Uses ffba_pkg.
module ffba_pick #(
  parameter int unsigned MAX_SEGMENTS = ffba_pkg::DEF_MAX_SEGMENTS
) (
  input  logic [MAX_SEGMENTS-1:0] cand_i,
  input  logic [MAX_SEGMENTS-1:0] exact_i,
  input  logic [MAX_SEGMENTS-1:0] nxt_i,
  input  logic [MAX_SEGMENTS-1:0] prv_i,
  input  logic                    mode_i,
  input  logic                    table_full_i,
  output logic [MAX_SEGMENTS-1:0] sel_o,
  output logic [MAX_SEGMENTS-1:0] after_o,
  output ffba_pkg::ffba_dec_t     dec_o
);
  import ffba_pkg::*;

  logic [MAX_SEGMENTS-1:0] one_v;
  logic                    found;
  logic                    exact_hit;

  assign one_v = {{(MAX_SEGMENTS-1){1'b0}}, 1'b1};

  // Lowest set bit, and every position strictly above it.
  assign sel_o   = cand_i & (~cand_i + one_v);
  assign after_o = ~(cand_i ^ (cand_i - one_v));

  assign found     = |cand_i;
  assign exact_hit = |(sel_o & exact_i);

  always_comb begin
    dec_o            = '0;
    dec_o.op         = OP_NONE;
    dec_o.status     = STATUS_OK;
    dec_o.merge_next = |nxt_i;
    dec_o.merge_prev = |prv_i;
    if (!found) begin
      dec_o.status = (mode_i == MODE_FREE) ? STATUS_BADADDR : STATUS_NOSPACE;
    end else if (mode_i == MODE_FREE) begin
      dec_o.op = OP_FREE;
    end else if (exact_hit) begin
      dec_o.op = OP_EXACT;
    end else if (table_full_i) begin
      dec_o.status = STATUS_FULL;
    end else begin
      dec_o.op = OP_SPLIT;
    end
  end

endmodule

// ===== design/first_fit_block_allocator.sv =====
// First-fit block allocator: a chain of segment cells, the pick stage and the
// request sequencer with its output register. Uses ffba_pkg, ffba_cell, ffba_pick.
//
// The arena is kept as an address-ordered table of up to MAX_SEGMENTS segments,
// one per cell; a header of HEADER_BYTES precedes every payload. Each request
// goes through the idle, evaluate and apply states in turn: the beat is taken
// in idle, every cell compares its segment against the request in evaluate,
// and in apply the first fitting (or matching) cell is picked and the whole
// chain updates, shifting entries by one place on a split and by one or two
// places on a merge. The result then sits in an output register; a new request
// is taken as soon as the chain is done, even while that result waits. The apply
// state waits only while the previous result is still held. The table is ready
// directly after reset with one free segment spanning the whole arena.
module first_fit_block_allocator #(
  parameter int unsigned ARENA_BYTES  = ffba_pkg::DEF_ARENA_BYTES,
  parameter int unsigned HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES,
  parameter int unsigned MAX_SEGMENTS = ffba_pkg::DEF_MAX_SEGMENTS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ffba_pkg::ffba_req_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ffba_pkg::ffba_rsp_t out_data_o
);
  import ffba_pkg::*;

  localparam logic [15:0] SIZE_RST = 16'(ARENA_BYTES - HEADER_BYTES);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0] state_q, state_d;
  ffba_req_t  req_q;
  logic       out_valid_q, out_valid_d;
  ffba_rsp_t  out_q;

  ffba_ctrl_t ctrl;
  ffba_dec_t  dec;
  logic       in_fire;
  logic       apply_fire;

  ffba_seg_t               seg_w  [MAX_SEGMENTS];
  ffba_flag_t              flag_w [MAX_SEGMENTS];
  logic [15:0]             addr_w [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] cand_v, exact_v, nxt_v, prv_v;
  logic [MAX_SEGMENTS-1:0] sel_v, after_v;
  logic [15:0]             grant_addr;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign apply_fire = (state_q == S_APPLY) & (~out_valid_q | ~out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_EVAL;
      S_EVAL:  state_d = S_APPLY;
      S_APPLY: if (apply_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.eval_en    = (state_q == S_EVAL);
    ctrl.apply_en   = apply_fire;
    ctrl.op         = dec.op;
    ctrl.mode       = req_q.mode;
    ctrl.req        = req_q.request_bytes;
    ctrl.addr       = req_q.free_address;
    ctrl.merge_next = dec.merge_next;
    ctrl.merge_prev = dec.merge_prev;
  end

  for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
    ffba_seg_t left_s, right1_s, right2_s;
    logic      sel_left_s, after_left_s, sel_right_s;

    if (g == 0) begin : g_left_edge
      assign left_s       = '0;
      assign sel_left_s   = 1'b0;
      assign after_left_s = 1'b0;
    end else begin : g_left
      assign left_s       = seg_w[g-1];
      assign sel_left_s   = sel_v[g-1];
      assign after_left_s = after_v[g-1];
    end

    if (g + 1 < MAX_SEGMENTS) begin : g_right1
      assign right1_s    = seg_w[g+1];
      assign sel_right_s = sel_v[g+1];
    end else begin : g_right1_edge
      assign right1_s    = '0;
      assign sel_right_s = 1'b0;
    end

    if (g + 2 < MAX_SEGMENTS) begin : g_right2
      assign right2_s = seg_w[g+2];
    end else begin : g_right2_edge
      assign right2_s = '0;
    end

    ffba_cell #(
      .HEADER_BYTES(HEADER_BYTES),
      .IS_HEAD     (g == 0),
      .SIZE_RST    (SIZE_RST)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .left_i      (left_s),
      .right1_i    (right1_s),
      .right2_i    (right2_s),
      .sel_left_i  (sel_left_s),
      .after_left_i(after_left_s),
      .sel_self_i  (sel_v[g]),
      .after_self_i(after_v[g]),
      .sel_right_i (sel_right_s),
      .seg_o       (seg_w[g]),
      .flag_o      (flag_w[g]),
      .addr_o      (addr_w[g])
    );

    assign cand_v[g]  = flag_w[g].cand;
    assign exact_v[g] = flag_w[g].exact;
    assign nxt_v[g]   = flag_w[g].nxt;
    assign prv_v[g]   = flag_w[g].prv;
  end

  ffba_pick #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_pick (
    .cand_i      (cand_v),
    .exact_i     (exact_v),
    .nxt_i       (nxt_v),
    .prv_i       (prv_v),
    .mode_i      (req_q.mode),
    .table_full_i(seg_w[MAX_SEGMENTS-1].valid),
    .sel_o       (sel_v),
    .after_o     (after_v),
    .dec_o       (dec)
  );

  // Only the selected cell drives a nonzero address.
  always_comb begin
    grant_addr = 16'd0;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      grant_addr = grant_addr | addr_w[i];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (apply_fire) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) req_q <= in_data_i;
    if (apply_fire) begin
      out_q.status          <= dec.status;
      out_q.payload_address <= (dec.op == OP_EXACT || dec.op == OP_SPLIT) ?
                               grant_addr : 16'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/ffba_checker.sv =====
// Port checker for the first-fit block allocator, bound to its top level.
// Uses ffba_pkg for the beat types and status codes.
module ffba_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_i,
  input logic                out_valid_i,
  input logic                out_stall_i,
  input ffba_pkg::ffba_rsp_t out_data_i
);
  import ffba_pkg::*;

  // A taken request keeps the input side stalled while the chain works on it.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_i) |=> in_stall_i)
    else $error("input not stalled after a request beat");

  // A failed request never carries an address.
  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_data_i.status != STATUS_OK) |-> (out_data_i.payload_address == 16'd0))
    else $error("failed result carries an address");

  // A new result only appears once a request has been worked on.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_stall_i))
    else $error("result appeared without a request in progress");

  // A held result beat stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_stall_i) |=> (out_valid_i && $stable(out_data_i)))
    else $error("stalled result beat changed");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_i (in_stall_o),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_i (out_data_o)
);

// ===== tb/first_fit_block_allocator_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for first_fit_block_allocator: directed, table-full and random tests
// against a segment-table predictor, with random sender bursts and receiver stalls.
// Depends on ffba_pkg and the allocator RTL only.
module first_fit_block_allocator_tb;
  import ffba_pkg::*;

  localparam int unsigned ARENA       = DEF_ARENA_BYTES;
  localparam int unsigned HDR         = DEF_HEADER_BYTES;
  localparam int unsigned MAX_SEG     = DEF_MAX_SEGMENTS;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned RANDOM_REQS = 1800;

  localparam int STALL_NONE   = 0;
  localparam int STALL_RANDOM = 1;
  localparam int STALL_HOLD   = 2;

  typedef struct packed {
    logic [15:0] off;
    logic [15:0] len;
    logic        is_free;
  } seg_entry_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  ffba_req_t in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  ffba_rsp_t out_data_o;

  // Predicted segment table, kept in step with every accepted beat.
  seg_entry_t  seg_table[MAX_SEG];
  int unsigned seg_count;

  ffba_rsp_t   expected_rsp_q[$];
  ffba_rsp_t   oldest_rsp;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int          stall_mode = STALL_NONE;
  int unsigned stall_left = 0;

  first_fit_block_allocator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver stall pattern: quiet stretches, random stalls and long holds.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(STALL_NONE, STALL_HOLD);
      case (stall_mode)
        STALL_NONE:   stall_left = $urandom_range(20, 80);
        STALL_RANDOM: stall_left = $urandom_range(10, 40);
        default:      stall_left = $urandom_range(1, 15);
      endcase
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:   out_stall_i <= 1'b0;
      STALL_RANDOM: out_stall_i <= 1'($urandom_range(0, 1));
      default:      out_stall_i <= 1'b1;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, out_data_o);
        mismatch_count++;
      end else begin
        oldest_rsp = expected_rsp_q.pop_front();
        if (out_data_o.payload_address !== oldest_rsp.payload_address) begin
          $display("%0t: payload_address mismatch, expected %h, actual %h", $time,
                   oldest_rsp.payload_address, out_data_o.payload_address);
          mismatch_count++;
        end
        if (out_data_o.status !== oldest_rsp.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                   oldest_rsp.status, out_data_o.status);
          mismatch_count++;
        end
      end
    end
  end

  function automatic void remove_segment(int unsigned pos);
    for (int unsigned j = pos; j + 1 < seg_count; j++) seg_table[j] = seg_table[j + 1];
    seg_count--;
  endfunction

  // Applies one request to the predicted table and returns the result it yields.
  function automatic ffba_rsp_t allocator_outcome(ffba_req_t req);
    ffba_rsp_t   rsp;
    int unsigned hit;
    rsp.payload_address = '0;
    if (req.mode == MODE_ALLOC) begin
      rsp.status = STATUS_NOSPACE;
      for (int unsigned i = 0; i < seg_count; i++) begin
        if (seg_table[i].is_free) begin
          if (seg_table[i].len == req.request_bytes) begin
            seg_table[i].is_free = 1'b0;
            rsp.payload_address = 16'(seg_table[i].off + HDR);
            rsp.status = STATUS_OK;
            return rsp;
          end
          if (32'(seg_table[i].len) > 32'(req.request_bytes) + HDR) begin
            if (seg_count >= MAX_SEG) begin
              rsp.status = STATUS_FULL;
              return rsp;
            end
            for (int unsigned j = seg_count; j > i + 1; j--) seg_table[j] = seg_table[j - 1];
            seg_table[i + 1].off = 16'(seg_table[i].off + HDR + req.request_bytes);
            seg_table[i + 1].len = 16'(seg_table[i].len - req.request_bytes - HDR);
            seg_table[i + 1].is_free = 1'b1;
            seg_table[i].len = req.request_bytes;
            seg_table[i].is_free = 1'b0;
            seg_count++;
            rsp.payload_address = 16'(seg_table[i].off + HDR);
            rsp.status = STATUS_OK;
            return rsp;
          end
        end
      end
    end else begin
      hit = seg_count;
      for (int unsigned i = 0; i < seg_count; i++) begin
        if (32'(seg_table[i].off) + HDR == 32'(req.free_address) && !seg_table[i].is_free) begin
          hit = i;
          break;
        end
      end
      if (hit == seg_count) begin
        rsp.status = STATUS_BADADDR;
        return rsp;
      end
      seg_table[hit].is_free = 1'b1;
      if (hit + 1 < seg_count && seg_table[hit + 1].is_free) begin
        seg_table[hit].len = 16'(seg_table[hit].len + seg_table[hit + 1].len + HDR);
        remove_segment(hit + 1);
      end
      if (hit > 0 && seg_table[hit - 1].is_free) begin
        seg_table[hit - 1].len = 16'(seg_table[hit - 1].len + seg_table[hit].len + HDR);
        remove_segment(hit);
      end
      rsp.status = STATUS_OK;
    end
    return rsp;
  endfunction

  // Returns the index of a random segment with the given free mark, or -1.
  function automatic int pick_segment(logic want_free);
    int hits;
    int k;
    hits = 0;
    for (int i = 0; i < int'(seg_count); i++) if (seg_table[i].is_free == want_free) hits++;
    if (hits == 0) return -1;
    k = $urandom_range(0, hits - 1);
    for (int i = 0; i < int'(seg_count); i++) begin
      if (seg_table[i].is_free == want_free) begin
        if (k == 0) return i;
        k--;
      end
    end
    return -1;
  endfunction

  // Drives one beat, waits until it is taken, records its expected result, and
  // closes the current burst with an idle gap when the burst is used up.
  task automatic send_beat(ffba_req_t req);
    in_data_i  <= req;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    expected_rsp_q.push_back(allocator_outcome(req));
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  // The unused field carries random bits; the block must ignore it.
  task automatic alloc_beat(logic [15:0] bytes);
    ffba_req_t req;
    req.mode          = MODE_ALLOC;
    req.request_bytes = bytes;
    req.free_address  = 16'($urandom);
    send_beat(req);
  endtask

  task automatic free_beat(logic [15:0] addr);
    ffba_req_t req;
    req.mode          = MODE_FREE;
    req.request_bytes = 16'($urandom);
    req.free_address  = addr;
    send_beat(req);
  endtask

  task automatic wait_idle();
    while (expected_rsp_q.size() != 0) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Frees every allocated segment in random order.
  task automatic release_all();
    logic [15:0] live_q[$];
    logic [15:0] tmp;
    int unsigned j;
    for (int unsigned i = 0; i < seg_count; i++)
      if (!seg_table[i].is_free) live_q.push_back(16'(seg_table[i].off + HDR));
    for (int i = live_q.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = live_q[i];
      live_q[i] = live_q[j];
      live_q[j] = tmp;
    end
    foreach (live_q[i]) free_beat(live_q[i]);
  endtask

  task automatic test_directed();
    free_beat(16'(HDR));            // the initial segment is already free
    free_beat(16'h0000);
    free_beat(16'hFFFF);
    alloc_beat(16'hFFFF);
    alloc_beat(16'(ARENA - HDR + 1));
    alloc_beat(16'(ARENA - 2 * HDR)); // refused: the remainder would be only a header
    alloc_beat(16'(ARENA - HDR));   // exact fit of the whole arena
    alloc_beat(16'h0000);
    free_beat(16'(HDR));
    free_beat(16'(HDR));            // double free
    alloc_beat(16'h0000);           // zero-byte payload by splitting
    alloc_beat(16'd100);
    alloc_beat(16'd200);
    alloc_beat(16'd100);
    free_beat(16'(2 * HDR));        // hole between two allocated blocks
    alloc_beat(16'd100);            // exact fit back into that hole
    free_beat(16'(3 * HDR + 100));
    free_beat(16'(2 * HDR));
    free_beat(16'(HDR));
    free_beat(16'(4 * HDR + 300));  // merges on both sides down to one segment
    alloc_beat(16'hAAAA);
    alloc_beat(16'h5555);
    free_beat(16'h5555);
    free_beat(16'hAAAA);
    free_beat(16'(HDR));
  endtask

  task automatic test_table_full();
    int          idx;
    logic [15:0] len;
    release_all();
    while (seg_count < MAX_SEG) alloc_beat(16'($urandom_range(0, 300)));
    alloc_beat(16'd10);             // split refused with a full table
    idx = pick_segment(1'b0);
    len = seg_table[idx].len;
    free_beat(16'(seg_table[idx].off + HDR));
    alloc_beat(len);                // an exact fit still works when full
    alloc_beat(16'd1);
    idx = pick_segment(1'b1);
    if (idx >= 0) alloc_beat(seg_table[idx].len);
    release_all();
  endtask

  task automatic test_random();
    int unsigned choice;
    int unsigned size_sel;
    int unsigned shave;
    int          idx;
    logic [15:0] bytes;
    for (int unsigned n = 0; n < RANDOM_REQS; n++) begin
      choice = $urandom_range(0, 99);
      if (choice < 45 || pick_segment(1'b0) < 0) begin
        size_sel = $urandom_range(0, 19);
        idx = pick_segment(1'b1);
        if (size_sel < 12 || idx < 0) begin
          bytes = 16'($urandom_range(0, 512));
        end else if (size_sel < 15) begin
          bytes = seg_table[idx].len;
        end else if (size_sel < 17) begin
          // Sizes around the point where the remainder is too small to split.
          shave = $urandom_range(0, HDR + 2);
          bytes = (seg_table[idx].len >= shave) ? 16'(seg_table[idx].len - shave)
                                                : seg_table[idx].len;
        end else begin
          bytes = 16'($urandom);
        end
        alloc_beat(bytes);
      end else if (choice < 85) begin
        idx = pick_segment(1'b0);
        free_beat(16'(seg_table[idx].off + HDR));
      end else if (choice < 94) begin
        free_beat(16'($urandom));
      end else begin
        idx = pick_segment(1'b1);
        free_beat((idx >= 0) ? 16'(seg_table[idx].off + HDR) : 16'($urandom));
      end
      if (n % 400 == 399) release_all();
      if (n == RANDOM_REQS / 2) wait_idle();
    end
  endtask

  initial begin
    seg_table[0] = '{off: 16'd0, len: 16'(ARENA - HDR), is_free: 1'b1};
    seg_count = 1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_idle();
    test_table_full();
    wait_idle();
    test_random();
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ffba_pkg.sv
design/ffba_cell.sv
design/ffba_pick.sv
design/first_fit_block_allocator.sv
design/ffba_checker.sv
tb/first_fit_block_allocator_tb.sv
